### hw/rtl/tsr_pkg.sv
// Shared types and constants for the tap, shake and rest detector.
package tsr_pkg;

   // Widths of the scaled sample and of the configuration address and data.
   localparam int SAMPLE_W   = 10;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Raw samples are scaled down by two to the power of this shift.
   localparam int SCALE_SHIFT = 6;

   // Activity below this level counts as resting.
   localparam logic [10:0] REST_LEVEL = 11'd25;

   // Mean thresholds that pick the rest direction.
   localparam logic signed [11:0] REST_LEFT_MEAN  = 12'sd450;
   localparam logic signed [11:0] REST_RIGHT_MEAN = 12'sd550;

   // After a shake the hit holdoff is stretched by this factor.
   localparam int SHAKE_HOLDOFF_MULT = 10;

   // Configuration register reset values.
   localparam logic [8:0]  HIT_STEP_RESET    = 9'd50;
   localparam logic [10:0] SHAKE_LEVEL_RESET = 11'd200;
   localparam logic [15:0] DWELL_RESET       = 16'd20;
   localparam logic [15:0] HOLDOFF_RESET     = 16'd100;
   localparam logic [15:0] WINDOW_RESET      = 16'd50;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_HIT_STEP    = 3'd0,
      REG_SHAKE_LEVEL = 3'd1,
      REG_DWELL_COUNT = 3'd2,
      REG_HOLDOFF_MS  = 3'd3,
      REG_WINDOW_MS   = 3'd4
   } reg_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic signed [15:0] raw_sample;
      logic [31:0]        now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]  right_hit;
      logic [9:0]  left_hit;
      logic [10:0] shake_value;
      logic        rest_left;
      logic        rest_right;
      logic        window_open;
      logic [31:0] window_end_ms;
   } rsp_payload_type;

   typedef struct packed {
      logic [8:0]  hit_step;
      logic [10:0] shake_level;
      logic [15:0] dwell_count;
      logic [15:0] hit_holdoff_ms;
      logic [15:0] window_ms;
   } cfg_type;

   // Scaled sample of the current item and the moving mean that includes it.
   typedef struct packed {
      sample_type cur;
      sample_type mean;
   } avg_type;

endpackage

### hw/rtl/tsr_tap_cell.sv
// One cell of the averaging tap line: holds one scaled sample.
module tsr_tap_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  tsr_pkg::sample_type sample_in,
   output tsr_pkg::sample_type sample_out
);

   tsr_pkg::sample_type sample_ff;
   tsr_pkg::sample_type sample_in_mux;

   // The cell takes its neighbor's sample whenever the line advances.
   assign sample_in_mux = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_mux;
      end
   end

   assign sample_out = sample_ff;

endmodule

### hw/rtl/tsr_avg.sv
// Sample scaling, tap line of cells and running-sum moving average.
module tsr_avg #(
   parameter int TAPS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic signed [15:0]  raw_sample,
   output tsr_pkg::avg_type    avg_out
);

   localparam int L_W    = $clog2(TAPS);
   localparam int SUM_W  = tsr_pkg::SAMPLE_W + L_W;
   localparam int OFFSET = (1 << (tsr_pkg::SAMPLE_W - 1)) * TAPS;
   // Reciprocal for an exact floor division of a SUM_W-bit value by TAPS.
   localparam int SHIFT  = SUM_W + L_W;
   localparam int MULT_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + MULT_W;
   localparam logic [MULT_W-1:0] MULT = MULT_W'(((1 << SHIFT) + TAPS - 1) / TAPS);

   tsr_pkg::sample_type cur;
   tsr_pkg::sample_type line [TAPS+1];

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0]        biased;
   logic [PROD_W-1:0]       prod;
   logic [tsr_pkg::SAMPLE_W-1:0] quot;

   // Arithmetic shift floors toward minus infinity.
   assign cur     = tsr_pkg::sample_type'(raw_sample >>> tsr_pkg::SCALE_SHIFT);
   assign line[0] = cur;

   genvar gi;
   generate
      for (gi = 0; gi < TAPS; gi++) begin : g_cell
         tsr_tap_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .sample_in  (line[gi]),
            .sample_out (line[gi+1])
         );
      end
   endgenerate

   // The last cell holds the sample that leaves the window with this item.
   assign sum_in = sum_ff - SUM_W'(line[TAPS]) + SUM_W'(cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (shift_en) begin
         sum_ff <= sum_in;
      end
   end

   // Bias the sum to be non-negative, divide, then remove the bias again.
   assign biased = $unsigned(sum_in) + SUM_W'(OFFSET);
   assign prod   = PROD_W'(biased) * PROD_W'(MULT);
   assign quot   = prod[SHIFT +: tsr_pkg::SAMPLE_W];

   assign avg_out.cur  = cur;
   assign avg_out.mean = tsr_pkg::sample_type'({~quot[tsr_pkg::SAMPLE_W-1],
                                                 quot[tsr_pkg::SAMPLE_W-2:0]});

endmodule

### hw/rtl/tsr_detect.sv
// Hit detection, holdoff timing and the shake and rest gesture counters.
module tsr_detect (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [31:0]              now_ms,
   input  tsr_pkg::avg_type         avg_in,
   input  tsr_pkg::cfg_type         cfg,
   output tsr_pkg::rsp_payload_type result
);

   tsr_pkg::sample_type last_scaled_ff;
   logic [10:0] activity_ff, activity_in;
   logic        armed_ff, armed_in;
   logic [31:0] rearm_time_ff, rearm_time_in;
   logic [15:0] shake_wait_ff, shake_wait_in;
   logic [15:0] rest_wait_ff, rest_wait_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [10:0] shake_held_ff, shake_held_in;
   logic        rest_left_ff, rest_left_in;
   logic        rest_right_ff, rest_right_in;

   logic signed [10:0] dev_diff;
   logic [9:0]         dev;
   logic signed [11:0] d_prev;
   logic signed [11:0] cur_x, mean_x, step_x, step2_x;
   logic               armed_now, fall, rise, right, left, hit, armed_post;
   logic [19:0]        holdoff_long;

   assign cur_x   = 12'(avg_in.cur);
   assign mean_x  = 12'(avg_in.mean);
   assign step_x  = $signed({3'b000, cfg.hit_step});
   assign step2_x = $signed({2'b00, cfg.hit_step, 1'b0});
   assign d_prev  = cur_x - 12'(last_scaled_ff);

   assign dev_diff = 11'(avg_in.cur) - 11'(avg_in.mean);
   assign dev      = dev_diff[10] ? 10'(-dev_diff) : dev_diff[9:0];

   assign armed_now = armed_ff | (now_ms > rearm_time_ff);
   assign fall      = (d_prev < -step_x) && (cur_x < mean_x - step2_x);
   assign rise      = (d_prev > step_x) && (cur_x > mean_x + step2_x);
   // A falling hit disarms, so a rising hit cannot follow in the same item.
   assign right      = fall & armed_now;
   assign left       = rise & armed_now & ~right;
   assign hit        = right | left;
   assign armed_post = armed_now & ~hit;

   assign activity_in  = {1'b0, activity_ff[10:1]} + {1'b0, dev};
   assign holdoff_long = 20'(cfg.hit_holdoff_ms) * 20'(tsr_pkg::SHAKE_HOLDOFF_MULT);

   always_comb begin
      armed_in      = armed_post;
      rearm_time_in = hit ? now_ms + 32'(cfg.hit_holdoff_ms) : rearm_time_ff;
      shake_wait_in = shake_wait_ff;
      rest_wait_in  = rest_wait_ff;
      timeout_in    = timeout_ff;
      shake_held_in = shake_held_ff;
      rest_left_in  = rest_left_ff;
      rest_right_in = rest_right_ff;
      if (activity_in > cfg.shake_level) begin
         if (shake_wait_ff == '0) begin
            if (armed_post) begin
               shake_held_in = activity_in;
               armed_in      = 1'b0;
               rearm_time_in = now_ms + 32'(holdoff_long);
               rest_left_in  = 1'b0;
               rest_right_in = 1'b0;
            end else begin
               shake_held_in = '0;
            end
         end else begin
            shake_wait_in = shake_wait_ff - 16'd1;
         end
         rest_wait_in = cfg.dwell_count;
         timeout_in   = cfg.dwell_count;
      end else if (activity_in < tsr_pkg::REST_LEVEL && mean_x < tsr_pkg::REST_LEFT_MEAN) begin
         if (rest_wait_ff == '0) begin
            rest_left_in  = 1'b1;
            rest_right_in = 1'b0;
            shake_held_in = '0;
         end else begin
            rest_wait_in = rest_wait_ff - 16'd1;
         end
         shake_wait_in = cfg.dwell_count;
         timeout_in    = cfg.dwell_count;
      end else if (activity_in < tsr_pkg::REST_LEVEL && mean_x > tsr_pkg::REST_RIGHT_MEAN) begin
         if (rest_wait_ff == '0) begin
            rest_right_in = 1'b1;
            rest_left_in  = 1'b0;
            shake_held_in = '0;
         end else begin
            rest_wait_in = rest_wait_ff - 16'd1;
         end
         shake_wait_in = cfg.dwell_count;
         timeout_in    = cfg.dwell_count;
      end else begin
         rest_wait_in  = cfg.dwell_count;
         shake_wait_in = cfg.dwell_count;
         if (timeout_ff == '0) begin
            rest_left_in  = 1'b0;
            rest_right_in = 1'b0;
            shake_held_in = '0;
         end else begin
            timeout_in = timeout_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scaled_ff <= '0;
         activity_ff    <= '0;
         armed_ff       <= 1'b1;
         rearm_time_ff  <= '0;
         shake_wait_ff  <= tsr_pkg::DWELL_RESET;
         rest_wait_ff   <= tsr_pkg::DWELL_RESET;
         timeout_ff     <= tsr_pkg::DWELL_RESET;
         shake_held_ff  <= '0;
         rest_left_ff   <= 1'b0;
         rest_right_ff  <= 1'b0;
      end else if (accept) begin
         last_scaled_ff <= avg_in.cur;
         activity_ff    <= activity_in;
         armed_ff       <= armed_in;
         rearm_time_ff  <= rearm_time_in;
         shake_wait_ff  <= shake_wait_in;
         rest_wait_ff   <= rest_wait_in;
         timeout_ff     <= timeout_in;
         shake_held_ff  <= shake_held_in;
         rest_left_ff   <= rest_left_in;
         rest_right_ff  <= rest_right_in;
      end
   end

   assign result.right_hit     = right ? dev : '0;
   assign result.left_hit      = left ? dev : '0;
   assign result.shake_value   = shake_held_in;
   assign result.rest_left     = rest_left_in;
   assign result.rest_right    = rest_right_in;
   assign result.window_open   = hit;
   assign result.window_end_ms = hit ? now_ms + 32'(cfg.window_ms) : '0;

endmodule

### hw/rtl/tap_shake_rest_detector_top.sv
// Top level of the tap, shake and rest detector with its register port.
//
// Each input item carries one raw signed accelerometer sample of one axis
// and a free-running millisecond timestamp. For every accepted item the
// block returns exactly one result item: right and left hit magnitudes,
// the held shake value and rest flags, and the start of a comparison
// window with its closing time.
// An item is accepted on a clock edge where req_valid is high and
// req_stall is low; results leave the same way on rsp_valid and rsp_stall.
// The result is loaded into the output register on the accepting clock edge.
// The block takes one item every cycle unless the output stalls; its tap
// line, running sum and reciprocal multiply for the mean reach the output
// register combinationally. When the receiver stalls, the output register
// holds its item and req_stall rises only while it waits; no item is lost.
// Reset loads the configuration registers with their defaults, clears the
// tap line, the running sum, the activity level and the held gestures,
// arms hit detection and reloads the dwell counters with the default.
// The user writes configuration over the APB-style csr_ port while idle; the
// block does not check it. Registers lie at byte addresses 0, 4, 8, 12, 16.
module tap_shake_rest_detector_top #(
   parameter int TAPS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tsr_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tsr_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   tsr_pkg::cfg_type         cfg_ff;
   tsr_pkg::reg_index_type   reg_index;
   tsr_pkg::avg_type         avg;
   tsr_pkg::rsp_payload_type result;
   tsr_pkg::rsp_payload_type rsp_payload_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_fire, csr_write;

   // Register port: always ready, written on the access phase of a write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = tsr_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_step       <= tsr_pkg::HIT_STEP_RESET;
         cfg_ff.shake_level    <= tsr_pkg::SHAKE_LEVEL_RESET;
         cfg_ff.dwell_count    <= tsr_pkg::DWELL_RESET;
         cfg_ff.hit_holdoff_ms <= tsr_pkg::HOLDOFF_RESET;
         cfg_ff.window_ms      <= tsr_pkg::WINDOW_RESET;
      end else if (csr_write) begin
         case (reg_index)
            tsr_pkg::REG_HIT_STEP:    cfg_ff.hit_step       <= csr_pwdata[8:0];
            tsr_pkg::REG_SHAKE_LEVEL: cfg_ff.shake_level    <= csr_pwdata[10:0];
            tsr_pkg::REG_DWELL_COUNT: cfg_ff.dwell_count    <= csr_pwdata[15:0];
            tsr_pkg::REG_HOLDOFF_MS:  cfg_ff.hit_holdoff_ms <= csr_pwdata[15:0];
            tsr_pkg::REG_WINDOW_MS:   cfg_ff.window_ms      <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         tsr_pkg::REG_HIT_STEP:    csr_prdata = 32'(cfg_ff.hit_step);
         tsr_pkg::REG_SHAKE_LEVEL: csr_prdata = 32'(cfg_ff.shake_level);
         tsr_pkg::REG_DWELL_COUNT: csr_prdata = 32'(cfg_ff.dwell_count);
         tsr_pkg::REG_HOLDOFF_MS:  csr_prdata = 32'(cfg_ff.hit_holdoff_ms);
         tsr_pkg::REG_WINDOW_MS:   csr_prdata = 32'(cfg_ff.window_ms);
         default:                  csr_prdata = '0;
      endcase
   end

   // Input side stalls only while a finished result waits on a stalled output.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   tsr_avg #(
      .TAPS (TAPS)
   ) u_avg (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (req_fire),
      .raw_sample (req_payload.raw_sample),
      .avg_out    (avg)
   );

   tsr_detect u_detect (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .now_ms (req_payload.now_ms),
      .avg_in (avg),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Output register: loads on every accepted item, holds while stalled.
   assign rsp_valid_in = req_fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // An accepted item always lands in the output register.
   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item did not reach the output register");

   // A window opens on exactly one hit, and only then carries a hit or end time.
   a_window_one_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.window_open |->
         ((rsp_payload_ff.right_hit != '0) != (rsp_payload_ff.left_hit != '0)))
      else $error("window opened without exactly one hit");

   a_no_window_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.window_open |->
         (rsp_payload_ff.right_hit == '0) && (rsp_payload_ff.left_hit == '0) &&
         (rsp_payload_ff.window_end_ms == '0))
      else $error("hit or window end without an open window");

   // Shake and the two rest states exclude one another.
   a_gesture_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         !(rsp_payload_ff.rest_left && rsp_payload_ff.rest_right) &&
         ((rsp_payload_ff.shake_value == '0) ||
          (!rsp_payload_ff.rest_left && !rsp_payload_ff.rest_right)))
      else $error("conflicting gesture states reported");
`endif

endmodule

### tb/tap_shake_rest_detector_checker.sv
// Scoreboard for the tap, shake and rest detector: predicts and checks every result item.
`timescale 1ns / 1ps

module tap_shake_rest_detector_checker
   import tsr_pkg::*;
#(
   parameter int TAPS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    sample_count,
   output int                    hit_count,
   output int                    shake_count,
   output int                    rest_count
);

   cfg_type                     cfg;
   logic signed [SAMPLE_W-1:0]  prev_scaled;
   logic signed [SAMPLE_W-1:0]  tap_hist [TAPS];
   int                          tap_wr;
   int                          run_sum;
   logic [10:0]                 activity;
   logic                        hits_armed;
   logic [31:0]                 rearm_at;
   logic [15:0]                 shake_wait, rest_wait, gesture_wait;
   logic [10:0]                 shake_hold;
   logic                        rest_left_hold, rest_right_hold;
   rsp_payload_type             gesture_results_q [$];
   int                          result_index;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got 0x%0h, wanted 0x%0h",
                                   result_index, name, got, want));
      end
   endtask

   task automatic clear_detector();
      cfg.hit_step       = HIT_STEP_RESET;
      cfg.shake_level    = SHAKE_LEVEL_RESET;
      cfg.dwell_count    = DWELL_RESET;
      cfg.hit_holdoff_ms = HOLDOFF_RESET;
      cfg.window_ms      = WINDOW_RESET;
      prev_scaled = '0;
      foreach (tap_hist[i]) tap_hist[i] = '0;
      tap_wr = 0;
      run_sum = 0;
      activity = '0;
      hits_armed = 1'b1;
      rearm_at = '0;
      shake_wait = DWELL_RESET;
      rest_wait = DWELL_RESET;
      gesture_wait = DWELL_RESET;
      shake_hold = '0;
      rest_left_hold = 1'b0;
      rest_right_hold = 1'b0;
   endtask

   // One sample through the averaging, hit and gesture logic.
   task automatic detect_gestures(input req_payload_type item, output rsp_payload_type res);
      logic signed [15:0] raw;
      logic [31:0]        now;
      int                 cur, mean, dev, step, act_sum;
      raw = item.raw_sample;
      now = item.now_ms;
      res = '0;
      cur = raw >>> SCALE_SHIFT;
      run_sum = run_sum - tap_hist[tap_wr] + cur;
      tap_hist[tap_wr] = SAMPLE_W'(cur);
      tap_wr = (tap_wr + 1) % TAPS;
      if (run_sum >= 0) begin
         mean = run_sum / TAPS;
      end else begin
         mean = -((-run_sum + TAPS - 1) / TAPS);
      end
      dev = (cur < mean) ? mean - cur : cur - mean;
      step = int'(cfg.hit_step);

      if (now > rearm_at) hits_armed = 1'b1;

      if (cur - prev_scaled < -step && cur < mean - 2 * step && hits_armed) begin
         res.right_hit = dev[9:0];
         hits_armed = 1'b0;
         rearm_at = now + cfg.hit_holdoff_ms;
         res.window_open = 1'b1;
         res.window_end_ms = now + cfg.window_ms;
      end
      if (cur - prev_scaled > step && cur > mean + 2 * step && hits_armed) begin
         res.left_hit = dev[9:0];
         hits_armed = 1'b0;
         rearm_at = now + cfg.hit_holdoff_ms;
         res.window_open = 1'b1;
         res.window_end_ms = now + cfg.window_ms;
      end

      act_sum = int'(activity >> 1) + dev;
      activity = act_sum[10:0];
      if (activity > cfg.shake_level) begin
         if (shake_wait == 0) begin
            if (hits_armed) begin
               shake_hold = activity;
               hits_armed = 1'b0;
               rearm_at = now + cfg.hit_holdoff_ms * 32'(SHAKE_HOLDOFF_MULT);
               rest_left_hold = 1'b0;
               rest_right_hold = 1'b0;
            end else begin
               shake_hold = '0;
            end
         end else begin
            shake_wait--;
         end
         rest_wait = cfg.dwell_count;
         gesture_wait = cfg.dwell_count;
      end else if (activity < REST_LEVEL && mean < REST_LEFT_MEAN) begin
         if (rest_wait == 0) begin
            rest_left_hold = 1'b1;
            rest_right_hold = 1'b0;
            shake_hold = '0;
         end else begin
            rest_wait--;
         end
         shake_wait = cfg.dwell_count;
         gesture_wait = cfg.dwell_count;
      end else if (activity < REST_LEVEL && mean > REST_RIGHT_MEAN) begin
         if (rest_wait == 0) begin
            rest_right_hold = 1'b1;
            rest_left_hold = 1'b0;
            shake_hold = '0;
         end else begin
            rest_wait--;
         end
         shake_wait = cfg.dwell_count;
         gesture_wait = cfg.dwell_count;
      end else begin
         rest_wait = cfg.dwell_count;
         shake_wait = cfg.dwell_count;
         if (gesture_wait == 0) begin
            rest_left_hold = 1'b0;
            rest_right_hold = 1'b0;
            shake_hold = '0;
         end else begin
            gesture_wait--;
         end
      end

      prev_scaled = SAMPLE_W'(cur);
      res.shake_value = shake_hold;
      res.rest_left = rest_left_hold;
      res.rest_right = rest_right_hold;
   endtask

   task automatic compare_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (gesture_results_q.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                   result_index));
      end else begin
         want = gesture_results_q.pop_front();
         check_field("right_hit", got.right_hit, want.right_hit);
         check_field("left_hit", got.left_hit, want.left_hit);
         check_field("shake_value", got.shake_value, want.shake_value);
         check_field("rest_left", got.rest_left, want.rest_left);
         check_field("rest_right", got.rest_right, want.rest_right);
         check_field("window_open", got.window_open, want.window_open);
         check_field("window_end_ms", got.window_end_ms, want.window_end_ms);
      end
      result_index++;
   endtask

   task automatic write_config(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      reg_index_type idx;
      idx = reg_index_type'(addr[CSR_ADDR_W-1:2]);
      case (idx)
         REG_HIT_STEP:    cfg.hit_step       = data[8:0];
         REG_SHAKE_LEVEL: cfg.shake_level    = data[10:0];
         REG_DWELL_COUNT: cfg.dwell_count    = data[15:0];
         REG_HOLDOFF_MS:  cfg.hit_holdoff_ms = data[15:0];
         REG_WINDOW_MS:   cfg.window_ms      = data[15:0];
         default: ;
      endcase
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      sample_count = 0;
      hit_count = 0;
      shake_count = 0;
      rest_count = 0;
      result_index = 0;
      clear_detector();
   end

   always @(posedge clock) begin
      rsp_payload_type pred;
      if (reset) begin
         clear_detector();
         gesture_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result(rsp_payload);
         if (req_valid && !req_stall) begin
            detect_gestures(req_payload, pred);
            gesture_results_q.push_back(pred);
            sample_count++;
            if (pred.window_open) hit_count++;
            if (pred.shake_value != 0) shake_count++;
            if (pred.rest_left || pred.rest_right) rest_count++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            write_config(csr_paddr, csr_pwdata);
         end
      end
      pending_count = gesture_results_q.size();
   end

endmodule

### tb/tap_shake_rest_detector_top_test.sv
// Top of the detector testbench: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module tap_shake_rest_detector_top_test;
   import tsr_pkg::*;

   // Kinds of motion that the random part strings together. Quiet stretches
   // lead to rest, occasional spikes on a quiet level give hits, and large
   // alternating swings build up the activity level to a shake.
   typedef enum int {
      MOTION_QUIET,
      MOTION_TAPS,
      MOTION_SHAKE,
      MOTION_NOISE
   } motion_kind_type;

   // Register settings that the run walks through.
   typedef enum int {
      CFG_LOW,
      CFG_HIGH,
      CFG_MID
   } cfg_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count, pending_count, sample_count, hit_count, shake_count, rest_count;

   // Percentages of cycles in which the sender holds back an item and the
   // receiver stalls; the stimulus changes them from phase to phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int settings_used = 1;

   // Generator state for the random motion, kept across calls so that a
   // segment may span a pause.
   motion_kind_type  motion_kind = MOTION_QUIET;
   int               motion_left = 0;
   int               motion_base = 0;
   int               motion_amp = 0;
   logic [31:0]      clock_ms = '0;

   tap_shake_rest_detector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tap_shake_rest_detector_checker #(.TAPS(8)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .sample_count  (sample_count),
      .hit_count     (hit_count),
      .shake_count   (shake_count),
      .rest_count    (rest_count)
   );

   // 8 ns clock period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver decides afresh at every falling edge whether to stall, so
   // stalls land on every phase of the result stream.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Safety net: the slowest correct run is far below this.
   initial begin
      #2_000_000;
      $display("tap_shake_rest_detector_top: mismatch");
      $finish;
   end

   // Offers one item. Any idle cycles come first, with valid low; once valid
   // is raised, it and the payload hold until the item is taken. Valid stays
   // high after acceptance until the next falling edge decides what follows,
   // so back-to-back items never see valid dropped and raised in one step.
   task automatic send_sample(input logic signed [15:0] raw, input logic [31:0] now);
      req_payload_type item;
      item.raw_sample = raw;
      item.now_ms = now;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds back input until every result item has come out, then lets the pipeline settle.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // A register write: setup cycle, then access cycle. The write lands on the
   // rising edge where psel, penable and pwrite meet pready.
   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Rewrites all five registers once the block is idle. The middle setting
   // also puts random junk above each register's width, which must be dropped.
   task automatic apply_settings(input cfg_kind_type kind);
      wait_for_drain();
      case (kind)
         CFG_LOW: begin
            write_reg(REG_HIT_STEP, 32'd0);
            write_reg(REG_SHAKE_LEVEL, 32'd0);
            write_reg(REG_DWELL_COUNT, 32'd0);
            write_reg(REG_HOLDOFF_MS, 32'd0);
            write_reg(REG_WINDOW_MS, 32'd0);
         end
         CFG_HIGH: begin
            write_reg(REG_HIT_STEP, 32'd511);
            write_reg(REG_SHAKE_LEVEL, 32'd2047);
            write_reg(REG_DWELL_COUNT, 32'd65535);
            write_reg(REG_HOLDOFF_MS, 32'd65535);
            write_reg(REG_WINDOW_MS, 32'd65535);
         end
         CFG_MID: begin
            write_reg(REG_HIT_STEP,
                      {23'($urandom), 9'($urandom_range(5, 80))});
            write_reg(REG_SHAKE_LEVEL,
                      {21'($urandom), 11'($urandom_range(40, 600))});
            write_reg(REG_DWELL_COUNT,
                      {16'($urandom), 16'($urandom_range(0, 30))});
            write_reg(REG_HOLDOFF_MS,
                      {16'($urandom), 16'($urandom_range(0, 400))});
            write_reg(REG_WINDOW_MS,
                      {16'($urandom), 16'($urandom)});
         end
         default: ;
      endcase
      settings_used++;
   endtask

   // Random motion built from segments of one kind each. Most segments are
   // shaped gestures with random content; a fifth are raw noise with jumps
   // in time. Some segments start just below the wrap of the millisecond
   // counter so that holdoff and window sums wrap.
   task automatic run_motion(input int count);
      int pick, value;
      for (int n = 0; n < count; n++) begin
         if (motion_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 30) motion_kind = MOTION_QUIET;
            else if (pick < 55) motion_kind = MOTION_TAPS;
            else if (pick < 80) motion_kind = MOTION_SHAKE;
            else motion_kind = MOTION_NOISE;
            motion_left = $urandom_range(15, 70);
            motion_base = int'($urandom_range(0, 65535)) - 32768;
            motion_amp = $urandom_range(2000, 32767);
            if ($urandom_range(9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
         end
         case (motion_kind)
            MOTION_QUIET: value = motion_base + int'($urandom_range(0, 160)) - 80;
            MOTION_TAPS: begin
               value = motion_base + int'($urandom_range(0, 160)) - 80;
               if ($urandom_range(7) == 0) begin
                  value = $urandom_range(1) ? motion_base + motion_amp
                                            : motion_base - motion_amp;
               end
            end
            MOTION_SHAKE: begin
               value = (motion_left % 2) ? motion_amp : -motion_amp;
               value = value + int'($urandom_range(0, 2000)) - 1000;
            end
            default: begin
               value = int'($urandom_range(0, 65535)) - 32768;
               if ($urandom_range(15) == 0) clock_ms = $urandom;
            end
         endcase
         if (value > 32767) value = 32767;
         if (value < -32768) value = -32768;
         clock_ms = clock_ms + $urandom_range(0, 40);
         send_sample(value[15:0], clock_ms);
         motion_left--;
      end
   endtask

   initial begin
      // Every input is known from time zero, and reset is held high at the start.
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset settings: step 50, holdoff 100 ms.
      send_idle_pct = 10;
      recv_idle_pct = 48;
      // A flat zero, then a full-scale fall gives a right hit at once.
      send_sample(16'sd0, 32'd0);
      send_sample(-16'sd32768, 32'd1);
      // Full-scale rise while held off: no hit.
      send_sample(16'sd32767, 32'd2);
      // Time equal to the rearm time keeps detection off; one later rearms
      // it and the rise is a left hit.
      send_sample(-16'sd32768, 32'd101);
      send_sample(16'sd32767, 32'd102);
      // Values around the scaling boundary, rounding toward minus infinity.
      send_sample(-16'sd1, 32'd300);
      send_sample(16'sd63, 32'd301);
      send_sample(16'sd64, 32'd302);
      send_sample(-16'sd64, 32'd303);
      send_sample(-16'sd65, 32'd304);
      // Hits just below the wrap of the timestamp: the rearm time wraps to a
      // small value, so the next sample is armed again.
      send_sample(-16'sd32768, 32'hFFFF_FFF0);
      send_sample(16'sd32767, 32'hFFFF_FFFF);
      // After the wrap, time zero is not past the wrapped rearm time.
      send_sample(-16'sd32768, 32'h0000_0000);
      send_sample(16'sd32767, 32'h0000_0064);
      // Alternating bit patterns on both fields.
      send_sample(16'sh5555, 32'h5555_5555);
      send_sample(16'shAAAA, 32'hAAAA_AAAA);
      send_sample(-16'sd32768, 32'hAAAA_AAFF);
      clock_ms = 32'hAAAA_AB00;

      // Random part. The sender idles lightly and the receiver heavily first.
      run_motion(300);
      apply_settings(CFG_LOW);
      run_motion(150);

      // The other way round from here on.
      send_idle_pct = 48;
      recv_idle_pct = 10;
      apply_settings(CFG_HIGH);
      run_motion(150);
      apply_settings(CFG_MID);
      run_motion(150);
      // Let the block run dry in the middle of a phase, then carry on.
      wait_for_drain();
      run_motion(150);

      // No idling at either side for the last phases.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(CFG_MID);
      run_motion(300);
      apply_settings(CFG_MID);
      run_motion(350);

      // Wait out the last results, then idle on to catch any strays.
      wait_for_drain();
      repeat (10) @(negedge clock);

      $display("Run covered %0d samples under %0d register settings.",
               sample_count, settings_used);
      $display("Results held %0d hits, %0d shake and %0d rest reports.",
               hit_count, shake_count, rest_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tap_shake_rest_detector_top: match");
      end else begin
         $display("tap_shake_rest_detector_top: mismatch");
      end
      $finish;
   end

endmodule
